// ----- rtl/core/calendar_clock_tick_defines.svh -----
// ----------------------------------------------------------------------------
// Calendar clock assertion macros
// Shared concurrent assertion wrappers, clocked on clk_i, off during reset.
// ----------------------------------------------------------------------------
`ifndef CALENDAR_CLOCK_TICK_DEFINES_SVH
`define CALENDAR_CLOCK_TICK_DEFINES_SVH

// a condition that must hold at every clock edge out of reset
`define CCT_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// antecedent in this cycle implies consequent in the next
`define CCT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/cct_pkg.sv -----
// ----------------------------------------------------------------------------
// Calendar clock package
// Time record type, item kinds, calendar constants and the leap year test.
// ----------------------------------------------------------------------------
package cct_pkg;

  typedef enum logic {
    KIND_TICK = 1'b0,
    KIND_LOAD = 1'b1
  } cct_kind_e;

  // packed so that seconds lands in the lowest bits
  typedef struct packed {
    logic        dst;
    logic [2:0]  weekday;
    logic [8:0]  day_of_year;
    logic [15:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hours;
    logic [5:0]  minutes;
    logic [5:0]  seconds;
  } cct_time_t;

  localparam int unsigned TimeW = $bits(cct_time_t);
  localparam int unsigned DataW = ((TimeW + 7) / 8) * 8;

  localparam logic [5:0] LastSecond = 6'd59;
  localparam logic [5:0] LastMinute = 6'd59;
  localparam logic [4:0] LastHour   = 5'd23;
  localparam logic [3:0] LastMonth  = 4'd11;
  localparam logic [3:0] February   = 4'd1;
  localparam logic [8:0] MaxYday    = 9'd365;

  localparam logic [4:0] MonthLen [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  // 25 * Inv25 == 1 mod 2^16; y is a multiple of 25 iff y * Inv25 mod 2^16
  // is at most floor((2^16 - 1) / 25)
  localparam logic [15:0] Inv25    = 16'd23593;
  localparam logic [15:0] Div25Max = 16'd2621;

  localparam cct_time_t ResetTime = '{
    dst:         1'b0,
    weekday:     3'd0,
    day_of_year: 9'd0,
    year:        16'd2000,
    month:       4'd0,
    day:         5'd1,
    hours:       5'd0,
    minutes:     6'd0,
    seconds:     6'd0
  };

  // Gregorian: div by 4, and either not by 25 or also by 16 (i.e. 400)
  function automatic logic is_leap(input logic [15:0] year);
    logic [31:0] prod;
    logic        div25;
    prod  = 32'(year) * 32'(Inv25);
    div25 = (prod[15:0] <= Div25Max);
    return (year[1:0] == 2'd0) && (!div25 || (year[3:2] == 2'd0));
  endfunction

endpackage

// ----- rtl/core/calendar_clock_tick.sv -----
// ----------------------------------------------------------------------------
// Calendar clock tick
// Real time clock and calendar counter: one-second ticks and full loads.
// ----------------------------------------------------------------------------
// channel  | dir | tdata (low bit first)                         | tuser
// s_axis   | in  | seconds, minutes, hours, day, month, year,    | kind
//          |     | day_of_year, weekday, dst, pad                |
// m_axis   | out | same layout as s_axis tdata                   | -
//
// One transaction in and one out per cycle when m_axis does not stall; an input
// register and a result register sit around a single pass of carry logic.
// The longest path is the leap year test (one 16x16 multiply) into the
// day carry. rst_ni clears the handshake and sets the time to 2000-01-01.
// Output stalls back up into the input register, then into s_axis_tready_o.
// ----------------------------------------------------------------------------
`include "calendar_clock_tick_defines.svh"

module calendar_clock_tick (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  // seconds, minutes, hours, day, month, year, day_of_year, weekday, dst
  input  logic [cct_pkg::DataW-1:0] s_axis_tdata_i,
  // kind
  input  logic                     s_axis_tuser_i,
  output logic                     m_axis_tvalid_o,
  input  logic                     m_axis_tready_i,
  // seconds, minutes, hours, day, month, year, day_of_year, weekday, dst
  output logic [cct_pkg::DataW-1:0] m_axis_tdata_o
);
  import cct_pkg::*;

  logic      in_valid_q, in_valid_d;
  cct_kind_e in_kind_q;
  cct_time_t in_data_q;
  logic      out_valid_q, out_valid_d;
  cct_time_t out_data_q;
  cct_time_t time_q, time_d;
  logic      s_accept, proc;

  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;
  assign proc            = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || proc;

  always_comb begin
    in_valid_d  = s_accept ? 1'b1 : (proc ? 1'b0 : in_valid_q);
    out_valid_d = proc ? 1'b1 : (m_axis_tready_i ? 1'b0 : out_valid_q);
  end

  // Tick carry chain
  logic [3:0] mon_sat;
  logic [4:0] mon_limit;
  logic       sec_wrap, min_wrap, hour_wrap;

  always_comb begin
    mon_sat   = (time_q.month > LastMonth) ? LastMonth : time_q.month;
    mon_limit = MonthLen[mon_sat];
    if (mon_sat == February && is_leap(time_q.year)) begin
      mon_limit = mon_limit + 5'd1;
    end
    sec_wrap  = (time_q.seconds >= LastSecond);
    min_wrap  = (time_q.minutes >= LastMinute);
    hour_wrap = (time_q.hours >= LastHour);
  end

  always_comb begin
    time_d = time_q;
    if (proc) begin
      unique case (in_kind_q)
        KIND_LOAD: begin
          time_d       = in_data_q;
          time_d.month = (in_data_q.month > LastMonth) ? LastMonth : in_data_q.month;
        end
        KIND_TICK: begin
          if (!sec_wrap) begin
            time_d.seconds = time_q.seconds + 6'd1;
          end else begin
            time_d.seconds = '0;
            if (!min_wrap) begin
              time_d.minutes = time_q.minutes + 6'd1;
            end else begin
              time_d.minutes = '0;
              if (!hour_wrap) begin
                time_d.hours = time_q.hours + 5'd1;
              end else begin
                time_d.hours       = '0;
                time_d.day_of_year = (time_q.day_of_year >= MaxYday) ? MaxYday
                                   : time_q.day_of_year + 9'd1;
                if (time_q.day >= mon_limit) begin
                  time_d.day = 5'd1;
                  if (mon_sat == LastMonth) begin
                    // new year
                    time_d.month       = '0;
                    time_d.day_of_year = '0;
                    time_d.year        = time_q.year + 16'd1;
                  end else begin
                    time_d.month = mon_sat + 4'd1;
                  end
                end else begin
                  time_d.day = time_q.day + 5'd1;
                end
              end
            end
          end
        end
        default: time_d = time_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      time_q      <= ResetTime;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      time_q      <= time_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_kind_q <= cct_kind_e'(s_axis_tuser_i);
      in_data_q <= cct_time_t'(s_axis_tdata_i[TimeW-1:0]);
    end
    if (proc) begin
      out_data_q <= time_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(DataW - TimeW){1'b0}}, out_data_q};

  `CCT_ASSERT(a_month_range, time_q.month <= LastMonth, "month counter above December")
  `CCT_ASSERT_NEXT(a_hold_no_proc, !proc, $stable(time_q), "time changed without a transaction")
  `CCT_ASSERT_NEXT(a_tick_keeps_wday, proc && in_kind_q == KIND_TICK,
    $stable(time_q.weekday) && $stable(time_q.dst), "tick changed weekday or dst")
  `CCT_ASSERT_NEXT(a_tick_seconds, proc && in_kind_q == KIND_TICK,
    time_q.seconds == '0 || time_q.seconds == $past(time_q.seconds) + 6'd1,
    "tick did not advance seconds")

endmodule

// ----- bench/calendar_clock_tick_test.sv -----
// ----------------------------------------------------------------------------
// Calendar clock tick testbench
// Sends tick and load transactions with random gaps on both sides. Every
// result is checked against a fixed expected time or an in-bench calendar
// model: a directed table first, then random load/tick runs, most near rollover.
// ----------------------------------------------------------------------------
module calendar_clock_tick_test;
  import cct_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned RandItems  = 1600;
  localparam int unsigned SettleCyc  = 8;
  localparam int unsigned DaysIn [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  typedef struct {
    cct_kind_e kind;
    cct_time_t data;
    bit        typed;
    cct_time_t want;
  } dir_row_t;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             s_axis_tvalid;
  logic             s_axis_tready;
  logic [DataW-1:0] s_axis_tdata;
  logic             s_axis_tuser;
  logic             m_axis_tvalid;
  logic             m_axis_tready;
  logic [DataW-1:0] m_axis_tdata;

  cct_time_t   cal_now;         // predicted calendar state
  cct_time_t   pending_times[$];
  dir_row_t    dir_rows[$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned sent_count = 0;

  calendar_clock_tick dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("** calendar_clock_tick: FAILED **");
      $finish;
    end
  end

  function automatic cct_time_t tm(input int sec, input int mn, input int hr, input int day,
                                   input int mon, input int yr, input int yd, input int wd,
                                   input int dst);
    cct_time_t t;
    t.seconds     = 6'(sec);
    t.minutes     = 6'(mn);
    t.hours       = 5'(hr);
    t.day         = 5'(day);
    t.month       = 4'(mon);
    t.year        = 16'(yr);
    t.day_of_year = 9'(yd);
    t.weekday     = 3'(wd);
    t.dst         = 1'(dst);
    return t;
  endfunction

  function automatic bit year_has_leap_day(input int unsigned y);
    return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
  endfunction

  function automatic int unsigned month_days(input int unsigned m, input int unsigned y);
    return DaysIn[m] + ((m == 1 && year_has_leap_day(y)) ? 1 : 0);
  endfunction

  // calendar after one transaction
  function automatic cct_time_t next_time(input cct_time_t cur, input cct_kind_e kind,
                                          input cct_time_t ld);
    cct_time_t   t;
    int unsigned m;
    int unsigned lim;
    t = cur;
    if (kind == KIND_LOAD) begin
      t = ld;
      if (ld.month > 4'd11) t.month = 4'd11;
      return t;
    end
    if (int'(t.seconds) + 1 < 60) begin
      t.seconds = t.seconds + 6'd1;
      return t;
    end
    t.seconds = '0;
    if (int'(t.minutes) + 1 < 60) begin
      t.minutes = t.minutes + 6'd1;
      return t;
    end
    t.minutes = '0;
    if (int'(t.hours) + 1 < 24) begin
      t.hours = t.hours + 5'd1;
      return t;
    end
    t.hours = '0;
    m   = (t.month > 4'd11) ? 11 : int'(t.month);
    lim = month_days(m, t.year);
    t.day_of_year = (t.day_of_year >= 9'd365) ? 9'd365 : t.day_of_year + 9'd1;
    if (int'(t.day) + 1 > lim) begin
      t.day = 5'd1;
      if (m + 1 > 11) begin
        t.month       = '0;
        t.day_of_year = '0;
        t.year        = t.year + 16'd1;
      end else begin
        t.month = 4'(m + 1);
      end
    end else begin
      t.day = t.day + 5'd1;
    end
    return t;
  endfunction

  function automatic cct_time_t noise_time();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[TimeW-1:0];
  endfunction

  task automatic add_row(input cct_kind_e kind, input cct_time_t data, input bit typed,
                         input cct_time_t want);
    dir_row_t r;
    r.kind  = kind;
    r.data  = data;
    r.typed = typed;
    r.want  = want;
    dir_rows.push_back(r);
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  // sender: entered just after posedge clk_i, returns once s_axis has accepted the item
  bit tx_steady = 1'b0;
  task automatic send_item(input cct_kind_e kind, input cct_time_t data, input bit typed,
                           input cct_time_t want);
    int unsigned gap;
    if ($urandom_range(0, 49) == 0) tx_steady = !tx_steady;
    gap = tx_steady ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= DataW'(data);
    do @(posedge clk_i); while (!s_axis_tready);
    cal_now = next_time(cal_now, kind, data);
    pending_times.push_back(typed ? want : cal_now);
    sent_count++;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_times.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    cct_time_t   ld;
    cct_time_t   none;
    int unsigned mon;
    int unsigned yr;
    int unsigned len;
    int unsigned runs;
    int unsigned pick;

    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tuser  = 1'b0;
    s_axis_tdata  = '0;
    cal_now       = tm(0, 0, 0, 1, 0, 2000, 0, 0, 0);
    none          = '0;

    add_row(KIND_TICK, noise_time(), 1, tm(1, 0, 0, 1, 0, 2000, 0, 0, 0));
    add_row(KIND_LOAD, tm(59, 59, 23, 31, 11, 1999, 364, 6, 1), 1,
            tm(59, 59, 23, 31, 11, 1999, 364, 6, 1));
    // new year: month and day of year clear
    add_row(KIND_TICK, noise_time(), 1, tm(0, 0, 0, 1, 0, 2000, 0, 6, 1));
    add_row(KIND_LOAD, tm(59, 59, 23, 28, 1, 2000, 58, 2, 0), 0, none);
    add_row(KIND_TICK, noise_time(), 0, none);
    add_row(KIND_LOAD, tm(59, 59, 23, 28, 1, 1900, 58, 3, 0), 0, none);
    add_row(KIND_TICK, noise_time(), 0, none);
    add_row(KIND_LOAD, tm(59, 59, 23, 28, 1, 2024, 58, 4, 1), 0, none);
    add_row(KIND_TICK, noise_time(), 0, none);
    add_row(KIND_LOAD, tm(59, 59, 23, 29, 1, 2024, 59, 4, 1), 0, none);
    add_row(KIND_TICK, noise_time(), 0, none);
    add_row(KIND_LOAD, tm(59, 59, 23, 28, 1, 2023, 58, 5, 0), 0, none);
    add_row(KIND_TICK, noise_time(), 0, none);
    add_row(KIND_LOAD, tm(59, 59, 23, 31, 11, 65535, 365, 1, 0), 1,
            tm(59, 59, 23, 31, 11, 65535, 365, 1, 0));
    // year wraps to zero
    add_row(KIND_TICK, noise_time(), 1, tm(0, 0, 0, 1, 0, 0, 0, 1, 0));
    // month above 11 saturates
    add_row(KIND_LOAD, tm(0, 0, 0, 1, 15, 2000, 0, 0, 0), 1, tm(0, 0, 0, 1, 11, 2000, 0, 0, 0));
    // out-of-range fields held as given, then rolled by the next tick
    add_row(KIND_LOAD, tm(63, 63, 31, 0, 9, 2001, 511, 7, 1), 1,
            tm(63, 63, 31, 0, 9, 2001, 511, 7, 1));
    add_row(KIND_TICK, noise_time(), 1, tm(0, 0, 0, 1, 9, 2001, 365, 7, 1));
    add_row(KIND_LOAD, tm(59, 59, 23, 31, 3, 2010, 120, 2, 0), 0, none);
    add_row(KIND_TICK, noise_time(), 0, none);
    add_row(KIND_LOAD, tm(59, 59, 23, 30, 5, 2011, 365, 0, 1), 0, none);
    add_row(KIND_TICK, noise_time(), 0, none);
    add_row(KIND_LOAD, tm(58, 59, 23, 14, 6, 2012, 200, 3, 0), 0, none);
    add_row(KIND_TICK, noise_time(), 0, none);
    add_row(KIND_TICK, noise_time(), 0, none);

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i])
      send_item(dir_rows[i].kind, dir_rows[i].data, dir_rows[i].typed, dir_rows[i].want);
    drain();

    while (sent_count < RandItems) begin
      if (sent_count >= RandItems / 2 && sent_count < RandItems / 2 + 20) drain();
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        // loaded just ahead of a rollover, then ticked towards or across it
        mon = $urandom_range(0, 11);
        case ($urandom_range(0, 4))
          0: yr = $urandom_range(0, 65535);
          1: yr = 400 * $urandom_range(0, 163);
          2: yr = 100 * $urandom_range(0, 655);
          3: yr = 4 * $urandom_range(0, 16383);
          default: yr = $urandom_range(65530, 65535);
        endcase
        len = month_days(mon, yr);
        ld = tm($urandom_range(50, 59),
                ($urandom_range(0, 3) == 0) ? $urandom_range(0, 59) : 59,
                ($urandom_range(0, 3) == 0) ? $urandom_range(0, 23) : 23,
                ($urandom_range(0, 3) == 0) ? $urandom_range(1, len) : $urandom_range(len - 1, len),
                mon, yr, $urandom_range(0, 365), $urandom_range(0, 6), $urandom_range(0, 1));
        send_item(KIND_LOAD, ld, 0, none);
        runs = $urandom_range(1, 15);
      end else if (pick < 9) begin
        send_item(KIND_LOAD, noise_time(), 0, none);
        runs = $urandom_range(0, 4);
      end else begin
        runs = $urandom_range(1, 5);
      end
      repeat (runs) send_item(KIND_TICK, noise_time(), 0, none);
    end

    drain();
    repeat (SettleCyc) @(posedge clk_i);
    if (mismatch_count == 0 && pending_times.size() == 0) begin
      $display("** calendar_clock_tick: PASSED **");
    end else begin
      $display("** calendar_clock_tick: FAILED **");
    end
    $finish;
  end

  // result side: random stalls, each transaction checked in order
  initial begin
    int unsigned gap;
    bit          rx_steady;
    cct_time_t   got;
    cct_time_t   want;

    m_axis_tready = 1'b0;
    rx_steady     = 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 49) == 0) rx_steady = !rx_steady;
      gap = rx_steady ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      got = m_axis_tdata[TimeW-1:0];
      if (pending_times.size() == 0) begin
        $error("result transaction with no prediction waiting");
        mismatch_count++;
      end else begin
        want = pending_times.pop_front();
        check_field("seconds", want.seconds, got.seconds);
        check_field("minutes", want.minutes, got.minutes);
        check_field("hours", want.hours, got.hours);
        check_field("day", want.day, got.day);
        check_field("month", want.month, got.month);
        check_field("year", want.year, got.year);
        check_field("day_of_year", want.day_of_year, got.day_of_year);
        check_field("weekday", want.weekday, got.weekday);
        check_field("dst", want.dst, got.dst);
      end
    end
  end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/cct_pkg.sv
rtl/core/calendar_clock_tick.sv
bench/calendar_clock_tick_test.sv
